// ===== rtl/lrv_pkg.sv =====
// Shared types and constants for the log range to realized volatility ratio block.
// Used by the front queue, the log unit, the back end and the top level.
package lrv_pkg;

    // One bar after classification by the front end.
    typedef struct packed {
        logic signed [31:0] high_price;
        logic signed [31:0] low_price;
        logic signed [31:0] close_price;
        logic               range_valid;
        logic               close_ok;
        logic               row_end;
    } bar_t;

    // Request to the log-ratio unit: ln(num/den), both positive Q16.16.
    typedef struct packed {
        logic        start;
        logic [30:0] num;
        logic [30:0] den;
    } ln_req_t;

    // Response of the log-ratio unit, result in signed Q4.28.
    typedef struct packed {
        logic               done;
        logic signed [31:0] result;
    } ln_rsp_t;

    // ln(2) in Q0.31.
    localparam logic [30:0] LN2_Q31 = 31'd1488522236;

    localparam int LOG_ITERS  = 32;
    localparam int SQRT_ITERS = 32;
    localparam int DIV_ITERS  = 48;

    // Position of the highest set bit of a 31-bit value.
    function automatic logic [4:0] msb_index(input logic [30:0] v);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 0; i < 31; i++)
        begin
            if (v[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/lrv_front.sv =====
// Input side: accepts bars, classifies the last price, and queues them.
// Depends on lrv_pkg for the queued bar type.
module lrv_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [95:0]         s_axis_tdata,   // high_price, low_price, close_price
    input  logic [1:0]          s_axis_tuser,   // range_valid, close_valid
    input  logic                s_axis_tlast,   // row_end
    output logic                q_valid,
    input  logic                q_ready,
    output lrv_pkg::bar_t       q_item
);
    import lrv_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bar_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    bar_t             in_bar;
    logic             push;
    logic             pop;

    // Classify the incoming bar: a last price counts only if present and positive.
    always_comb
    begin
        in_bar.high_price  = $signed(s_axis_tdata[31:0]);
        in_bar.low_price   = $signed(s_axis_tdata[63:32]);
        in_bar.close_price = $signed(s_axis_tdata[95:64]);
        in_bar.range_valid = s_axis_tuser[0];
        in_bar.close_ok    = s_axis_tuser[1] && ($signed(s_axis_tdata[95:64]) > 32'sd0);
        in_bar.row_end     = s_axis_tlast;
    end

    assign s_axis_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_valid && q_ready;
    assign q_item        = entry_reg[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_bar;
        end
    end

endmodule

// ===== rtl/lrv_ln.sv =====
// Iterative log-ratio unit: ln(num/den) in signed Q4.28 by repeated squaring.
// Depends on lrv_pkg for request and response types and constants.
module lrv_ln (
    input  logic             clk,
    input  logic             rst_n,
    input  lrv_pkg::ln_req_t req,
    output lrv_pkg::ln_rsp_t rsp
);
    import lrv_pkg::*;

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_LOGA = 3'd1;
    localparam logic [2:0] L_LOGB = 3'd2;
    localparam logic [2:0] L_PP0  = 3'd3;
    localparam logic [2:0] L_PP1  = 3'd4;
    localparam logic [2:0] L_FIN  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [4:0]         it_reg, it_next;
    logic [30:0]        den_reg, den_next;
    logic [30:0]        m_reg, m_next;
    logic [31:0]        frac_reg, frac_next;
    logic signed [5:0]  ip_reg, ip_next;
    logic signed [37:0] la_reg, la_next;
    logic [32:0]        ms_reg, ms_next;
    logic               neg_reg, neg_next;
    logic [63:0]        acc_reg, acc_next;
    logic signed [31:0] result_reg, result_next;
    logic               done_reg, done_next;

    logic [61:0]        prod;
    logic [31:0]        sq_top;
    logic [30:0]        m_step;
    logic [31:0]        frac_new;
    logic signed [37:0] log_new;
    logic [30:0]        norm_src;
    logic [4:0]         norm_p;
    logic [30:0]        norm_m;
    logic signed [5:0]  norm_ip;
    logic signed [38:0] diff;
    logic [38:0]        diff_mag;
    logic [47:0]        pp_lo;
    logic [46:0]        pp_hi;
    logic [63:0]        rnd;
    logic [32:0]        mag_r;

    // One squaring step of the mantissa; a carry past 2.0 yields a fraction bit.
    always_comb
    begin
        prod     = m_reg * m_reg;
        sq_top   = prod[61:30];
        m_step   = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
        frac_new = {frac_reg[30:0], sq_top[31]};
        log_new  = $signed({ip_reg, frac_new});
    end

    // Normalize an operand to a Q1.30 mantissa and its integer log.
    always_comb
    begin
        norm_src = (state_reg == L_IDLE) ? req.num : den_reg;
        norm_p   = msb_index(norm_src);
        norm_m   = norm_src << (5'd30 - norm_p);
        norm_ip  = $signed({1'b0, norm_p}) - 6'sd16;
    end

    // Difference of logs and the partial products with ln(2).
    always_comb
    begin
        diff     = 39'(la_reg) - 39'(log_new);
        diff_mag = diff[38] ? 39'(-diff) : 39'(diff);
        pp_lo    = ms_reg[16:0] * LN2_Q31;
        pp_hi    = ms_reg[32:17] * LN2_Q31;
        rnd      = acc_reg + (64'd1 << 30);
        mag_r    = rnd[63:31];
    end

    always_comb
    begin
        state_next  = state_reg;
        it_next     = it_reg;
        den_next    = den_reg;
        m_next      = m_reg;
        frac_next   = frac_reg;
        ip_next     = ip_reg;
        la_next     = la_reg;
        ms_next     = ms_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            L_IDLE:
            begin
                if (req.start)
                begin
                    den_next   = req.den;
                    m_next     = norm_m;
                    ip_next    = norm_ip;
                    frac_next  = '0;
                    it_next    = '0;
                    state_next = L_LOGA;
                end
            end
            L_LOGA:
            begin
                m_next    = m_step;
                frac_next = frac_new;
                it_next   = it_reg + 1'b1;
                if (it_reg == 5'(LOG_ITERS - 1))
                begin
                    la_next    = log_new;
                    m_next     = norm_m;
                    ip_next    = norm_ip;
                    frac_next  = '0;
                    state_next = L_LOGB;
                end
            end
            L_LOGB:
            begin
                m_next    = m_step;
                frac_next = frac_new;
                it_next   = it_reg + 1'b1;
                if (it_reg == 5'(LOG_ITERS - 1))
                begin
                    neg_next   = diff[38];
                    ms_next    = diff_mag[36:4];
                    state_next = L_PP0;
                end
            end
            L_PP0:
            begin
                acc_next   = {16'd0, pp_lo};
                state_next = L_PP1;
            end
            L_PP1:
            begin
                acc_next   = acc_reg + {pp_hi, 17'd0};
                state_next = L_FIN;
            end
            L_FIN:
            begin
                // Saturate to the signed 32-bit range.
                if (neg_reg)
                begin
                    result_next = (mag_r[32] || mag_r[31]) ? 32'sh8000_0000
                                                           : -$signed(mag_r[31:0]);
                end
                else
                begin
                    result_next = (mag_r[32] || mag_r[31]) ? 32'sh7FFF_FFFF
                                                           : $signed(mag_r[31:0]);
                end
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg     <= it_next;
        den_reg    <= den_next;
        m_reg      <= m_next;
        frac_reg   <= frac_next;
        ip_reg     <= ip_next;
        la_reg     <= la_next;
        ms_reg     <= ms_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

// ===== rtl/lrv_back.sv =====
// Back end: row accumulation, square root, division and the output register.
// Depends on lrv_pkg and instantiates the log-ratio unit lrv_ln.
module lrv_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  lrv_pkg::bar_t q_item,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [31:0]   m_axis_tdata,   // ratio
    output logic [0:0]    m_axis_tuser    // ratio_valid
);
    import lrv_pkg::*;

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_RET  = 4'd1;
    localparam logic [3:0] B_SQ   = 4'd2;
    localparam logic [3:0] B_ACC  = 4'd3;
    localparam logic [3:0] B_POST = 4'd4;
    localparam logic [3:0] B_LR   = 4'd5;
    localparam logic [3:0] B_SQRT = 4'd6;
    localparam logic [3:0] B_DIV  = 4'd7;
    localparam logic [3:0] B_EMIT = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic signed [31:0] max_high_reg, max_high_next;
    logic signed [31:0] min_low_reg, min_low_next;
    logic signed [31:0] prev_close_reg, prev_close_next;
    logic               prev_ok_reg, prev_ok_next;
    logic [63:0]        sum_reg, sum_next;
    logic               end_reg, end_next;
    logic [31:0]        rmag_reg, rmag_next;
    logic [63:0]        sq_reg, sq_next;
    logic [31:0]        lr_reg, lr_next;
    logic [63:0]        rt_rem_reg, rt_rem_next;
    logic [63:0]        rt_res_reg, rt_res_next;
    logic [63:0]        rt_bit_reg, rt_bit_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [31:0]        root_reg, root_next;
    logic [32:0]        dv_rem_reg, dv_rem_next;
    logic [47:0]        dv_num_reg, dv_num_next;
    logic [47:0]        quo_reg, quo_next;
    logic [31:0]        res_ratio_reg, res_ratio_next;
    logic               res_valid_reg, res_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_ratio_reg, out_ratio_next;
    logic               out_flag_reg, out_flag_next;

    ln_req_t            ln_req;
    ln_rsp_t            ln_rsp;
    logic               take;
    logic               ret_go;
    logic               row_ok;
    logic               out_free;
    logic [63:0]        sum_add;
    logic               sum_carry;
    logic [63:0]        rt_trial;
    logic [32:0]        dv_shift;
    logic               dv_ge;
    logic [31:0]        rmag_abs;

    lrv_ln u_ln (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ln_req),
        .rsp   (ln_rsp)
    );

    assign q_ready  = (state_reg == B_IDLE);
    assign take     = q_valid && q_ready;
    assign ret_go   = q_item.close_ok && prev_ok_reg;
    assign row_ok   = (max_high_reg > 32'sd0) && (min_low_reg > 32'sd0)
                      && (max_high_reg > min_low_reg) && (sum_reg != 64'd0);
    assign out_free = !out_valid_reg || m_axis_tready;

    // Log requests: a return between closes, or the row's log range.
    always_comb
    begin
        ln_req.start = 1'b0;
        ln_req.num   = q_item.close_price[30:0];
        ln_req.den   = prev_close_reg[30:0];
        if (take && ret_go)
        begin
            ln_req.start = 1'b1;
        end
        else if ((state_reg == B_POST) && end_reg && row_ok)
        begin
            ln_req.start = 1'b1;
            ln_req.num   = max_high_reg[30:0];
            ln_req.den   = min_low_reg[30:0];
        end
    end

    // Datapath helpers: saturating add, root step, divide step.
    always_comb
    begin
        {sum_carry, sum_add} = {1'b0, sum_reg} + {1'b0, sq_reg};
        rt_trial = rt_res_reg + rt_bit_reg;
        dv_shift = {dv_rem_reg[31:0], dv_num_reg[47]};
        dv_ge    = (dv_shift >= {1'b0, root_reg});
        rmag_abs = ln_rsp.result[31] ? 32'(-ln_rsp.result) : 32'(ln_rsp.result);
    end

    always_comb
    begin
        state_next      = state_reg;
        max_high_next   = max_high_reg;
        min_low_next    = min_low_reg;
        prev_close_next = prev_close_reg;
        prev_ok_next    = prev_ok_reg;
        sum_next        = sum_reg;
        end_next        = end_reg;
        rmag_next       = rmag_reg;
        sq_next         = sq_reg;
        lr_next         = lr_reg;
        rt_rem_next     = rt_rem_reg;
        rt_res_next     = rt_res_reg;
        rt_bit_next     = rt_bit_reg;
        cnt_next        = cnt_reg;
        root_next       = root_reg;
        dv_rem_next     = dv_rem_reg;
        dv_num_next     = dv_num_reg;
        quo_next        = quo_reg;
        res_ratio_next  = res_ratio_reg;
        res_valid_next  = res_valid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_ratio_next  = out_ratio_reg;
        out_flag_next   = out_flag_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    if (q_item.range_valid)
                    begin
                        if (q_item.high_price > max_high_reg)
                        begin
                            max_high_next = q_item.high_price;
                        end
                        if (q_item.low_price < min_low_reg)
                        begin
                            min_low_next = q_item.low_price;
                        end
                    end
                    prev_close_next = q_item.close_price;
                    prev_ok_next    = q_item.close_ok;
                    end_next        = q_item.row_end;
                    state_next      = ret_go ? B_RET : B_POST;
                end
            end
            B_RET:
            begin
                if (ln_rsp.done)
                begin
                    rmag_next  = rmag_abs;
                    state_next = B_SQ;
                end
            end
            B_SQ:
            begin
                sq_next    = rmag_reg * rmag_reg;
                state_next = B_ACC;
            end
            B_ACC:
            begin
                sum_next   = sum_carry ? '1 : sum_add;
                state_next = B_POST;
            end
            B_POST:
            begin
                if (!end_reg)
                begin
                    state_next = B_IDLE;
                end
                else if (row_ok)
                begin
                    state_next = B_LR;
                end
                else
                begin
                    res_ratio_next = '0;
                    res_valid_next = 1'b0;
                    state_next     = B_EMIT;
                end
            end
            B_LR:
            begin
                if (ln_rsp.done)
                begin
                    lr_next     = ln_rsp.result;
                    rt_rem_next = sum_reg;
                    rt_res_next = '0;
                    rt_bit_next = 64'd1 << 62;
                    cnt_next    = '0;
                    state_next  = B_SQRT;
                end
            end
            B_SQRT:
            begin
                // One result bit of the integer root per cycle.
                if (rt_rem_reg >= rt_trial)
                begin
                    rt_rem_next = rt_rem_reg - rt_trial;
                    rt_res_next = (rt_res_reg >> 1) + rt_bit_reg;
                end
                else
                begin
                    rt_res_next = rt_res_reg >> 1;
                end
                rt_bit_next = rt_bit_reg >> 2;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == 6'(SQRT_ITERS - 1))
                begin
                    root_next   = (rt_rem_reg >= rt_trial)
                                  ? 32'((rt_res_reg >> 1) + rt_bit_reg)
                                  : 32'(rt_res_reg >> 1);
                    dv_rem_next = '0;
                    dv_num_next = {lr_reg, 16'd0};
                    quo_next    = '0;
                    cnt_next    = '0;
                    state_next  = B_DIV;
                end
            end
            B_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                dv_rem_next = dv_ge ? (dv_shift - {1'b0, root_reg}) : dv_shift;
                dv_num_next = {dv_num_reg[46:0], 1'b0};
                quo_next    = {quo_reg[46:0], dv_ge};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == 6'(DIV_ITERS - 1))
                begin
                    res_ratio_next = (quo_reg[46:31] != 16'd0) ? '1
                                                               : {quo_reg[30:0], dv_ge};
                    res_valid_next = 1'b1;
                    state_next     = B_EMIT;
                end
            end
            B_EMIT:
            begin
                // Hand the result to the output register and clear the row.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_ratio_next  = res_ratio_reg;
                    out_flag_next   = res_valid_reg;
                    max_high_next   = 32'sh8000_0000;
                    min_low_next    = 32'sh7FFF_FFFF;
                    prev_close_next = '0;
                    prev_ok_next    = 1'b0;
                    sum_next        = '0;
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            max_high_reg   <= 32'sh8000_0000;
            min_low_reg    <= 32'sh7FFF_FFFF;
            prev_close_reg <= '0;
            prev_ok_reg    <= 1'b0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            max_high_reg   <= max_high_next;
            min_low_reg    <= min_low_next;
            prev_close_reg <= prev_close_next;
            prev_ok_reg    <= prev_ok_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg       <= end_next;
        rmag_reg      <= rmag_next;
        sq_reg        <= sq_next;
        lr_reg        <= lr_next;
        rt_rem_reg    <= rt_rem_next;
        rt_res_reg    <= rt_res_next;
        rt_bit_reg    <= rt_bit_next;
        cnt_reg       <= cnt_next;
        root_reg      <= root_next;
        dv_rem_reg    <= dv_rem_next;
        dv_num_reg    <= dv_num_next;
        quo_reg       <= quo_next;
        res_ratio_reg <= res_ratio_next;
        res_valid_reg <= res_valid_next;
        out_ratio_reg <= out_ratio_next;
        out_flag_reg  <= out_flag_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_ratio_reg;
    assign m_axis_tuser  = out_flag_reg;

endmodule

// ===== rtl/log_range_to_realized_vol_ratio_top.sv =====
// A bar with no return goes from idle straight to B_POST in the back end; a bar with
// a return waits in B_RET for the log unit (two 32-step log runs), then squares and
// adds; a row end adds the log range, a 32-step root and a 48-step division. The back
// end takes one bar at a time; the input queue takes bars while it works. Reset clears
// the queue, the row state (max high, min low, previous close, sum) and output valid.
module log_range_to_realized_vol_ratio_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // high_price, low_price, close_price
    input  logic [1:0]  s_axis_tuser,   // range_valid, close_valid
    input  logic        s_axis_tlast,   // row_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // ratio
    output logic [0:0]  m_axis_tuser    // ratio_valid
);
    import lrv_pkg::*;

    logic q_valid;
    logic q_ready;
    bar_t q_item;

    // Front end: accept and classify bars into the queue.
    lrv_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    // Back end: accumulate the row and compute the ratio.
    lrv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
